// ===== rtl/rsm_pkg.sv =====
`timescale 1ns / 1ps
package rsm_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int MED_W      = 33;
  localparam int ITEM_CNT_W = 7;

  typedef logic signed [VALUE_BITS-1:0] rsm_value_t;
  typedef logic [CNT_W-1:0]             rsm_count_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } rsm_cell_ctrl_t;

endpackage

// ===== rtl/running_set_median_core.sv =====
`timescale 1ns / 1ps
// Running median of a set of signed integers.
// Input channel (in_valid_i/in_ready_o) carries one word per value with
// last_i marking the final value of a set. Values enter a chain of sorting
// cells that keeps them in ascending order, inserting each accepted word.
// Once a store holds CAPACITY values, further words of the set are dropped
// and the overflow flag of the result is set.
// On the last word the chain shifts toward cell 0 (an overflowed set skips
// this) until the middle values reach cells 0 and 1, then one result word
// is loaded into the output register: median_twice_o (twice the median, 0
// on overflow), item_count_o and overflow_o. in_ready_o stays low from the
// last word until the result word is loaded into the output register.
// The output channel (out_valid_o/out_ready_i) holds its word until taken;
// new values are accepted while it waits, but a following last word holds
// in the shift phase until the output register frees up.
// Reset empties the set and drops any pending result.
module running_set_median_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [32:0] median_twice_o,
  output logic [6:0]  item_count_o,
  output logic        overflow_o
);
  import rsm_pkg::*;

  typedef enum logic {
    ST_RUN,
    ST_SHIFT
  } state_e;

  state_e         state_q;
  rsm_count_t     count_q;
  rsm_count_t     shift_cnt_q;
  logic           ovf_q;
  logic           out_valid_q;
  logic signed [MED_W-1:0]      median_q;
  logic [ITEM_CNT_W-1:0]        item_count_q;
  logic           out_ovf_q;

  rsm_cell_ctrl_t ctrl;
  rsm_value_t     new_value;
  rsm_value_t     cell_value [CAPACITY];
  logic           cell_gt    [CAPACITY];
  logic           accept;
  logic           room;
  rsm_count_t     new_count;
  logic           out_free;
  logic           out_load;
  logic signed [VALUE_BITS:0]   mid_lo;
  logic signed [VALUE_BITS:0]   mid_hi;
  logic signed [VALUE_BITS:0]   mid_sum;
  logic [CNT_W+ITEM_CNT_W-1:0]  count_ext;

  assign new_value   = rsm_value_t'(value_i[VALUE_BITS-1:0]);
  assign in_ready_o  = (state_q == ST_RUN);
  assign accept      = in_valid_i && in_ready_o;
  assign room        = count_q < rsm_count_t'(CAPACITY);
  assign new_count   = count_q + rsm_count_t'(room);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == ST_SHIFT) && (shift_cnt_q == '0) && out_free;
  assign ctrl.insert = accept && room;
  assign ctrl.shift  = (state_q == ST_SHIFT) && (shift_cnt_q != '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rsm_value_t prev_value;
    rsm_value_t next_value;
    logic       prev_gt;
    logic       occupied;

    assign occupied = rsm_count_t'(i) < count_q;

    if (i == 0) begin : g_first
      assign prev_value = new_value;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_value = cell_value[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_body
      assign next_value = cell_value[i+1];
    end

    rsm_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_value_i  (new_value),
      .occupied_i   (occupied),
      .prev_value_i (prev_value),
      .prev_gt_i    (prev_gt),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // After the shift, cell 0 holds the lower middle value
  assign mid_lo    = (VALUE_BITS+1)'(cell_value[0]);
  assign mid_hi    = count_q[0] ? mid_lo : (VALUE_BITS+1)'(cell_value[1]);
  assign mid_sum   = mid_lo + mid_hi;
  assign count_ext = (CNT_W+ITEM_CNT_W)'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      count_q      <= '0;
      shift_cnt_q  <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      median_q     <= '0;
      item_count_q <= '0;
      out_ovf_q    <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_RUN: begin
          if (accept) begin
            count_q <= new_count;
            if (!room) begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              // overflowed sets skip the shift, their median is forced to 0
              shift_cnt_q <= (ovf_q || !room) ? '0 :
                             ((new_count - rsm_count_t'(1)) >> 1);
              state_q     <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          if (shift_cnt_q != '0) begin
            shift_cnt_q <= shift_cnt_q - rsm_count_t'(1);
          end else if (out_free) begin
            median_q     <= ovf_q ? '0 : MED_W'(mid_sum);
            item_count_q <= count_ext[ITEM_CNT_W-1:0];
            out_ovf_q    <= ovf_q;
            count_q      <= '0;
            ovf_q        <= 1'b0;
            state_q      <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_twice_o = median_q;
  assign item_count_o   = item_count_q;
  assign overflow_o     = out_ovf_q;

endmodule

// ===== rtl/rsm_cell.sv =====
`timescale 1ns / 1ps
module rsm_cell (
  input  logic                   clk_i,
  input  rsm_pkg::rsm_cell_ctrl_t ctrl_i,
  input  rsm_pkg::rsm_value_t    new_value_i,
  input  logic                   occupied_i,
  input  rsm_pkg::rsm_value_t    prev_value_i,
  input  logic                   prev_gt_i,
  input  rsm_pkg::rsm_value_t    next_value_i,
  output rsm_pkg::rsm_value_t    value_o,
  output logic                   gt_o
);
  import rsm_pkg::*;

  rsm_value_t value_q;
  rsm_value_t value_d;

  // strict compare keeps equal values ahead of the new one
  assign gt_o    = occupied_i && (value_q > new_value_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert) begin
      if (prev_gt_i) begin
        value_d = prev_value_i;
      end else if (gt_o || !occupied_i) begin
        value_d = new_value_i;
      end
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== dv/running_set_median_checker.sv =====
`timescale 1ns / 1ps
module running_set_median_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [31:0]           value_i,
  input  logic                  last_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic signed [32:0]    median_twice_i,
  input  logic [6:0]            item_count_i,
  input  logic                  overflow_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o
);
  import rsm_pkg::*;

  typedef struct packed {
    logic signed [MED_W-1:0] median_twice;
    logic [ITEM_CNT_W-1:0]   item_count;
    logic                    overflow;
  } median_word_t;

  median_word_t medians_due_q[$];
  rsm_value_t   sorted_vals [CAPACITY];
  int unsigned  held_count;
  logic         set_overflowed;
  int unsigned  mismatches;

  // Keep ascending order; an equal value lands after the ones already held.
  task automatic insert_value(input rsm_value_t v);
    int pos;
    pos = int'(held_count);
    while (pos > 0 && sorted_vals[pos-1] > v) begin
      sorted_vals[pos] = sorted_vals[pos-1];
      pos--;
    end
    sorted_vals[pos] = v;
    held_count++;
  endtask

  function automatic logic signed [MED_W-1:0] twice_median();
    int unsigned half;
    logic signed [MED_W-1:0] hi_mid;
    logic signed [MED_W-1:0] lo_mid;
    if (set_overflowed || held_count == 0) return '0;
    half   = held_count / 2;
    hi_mid = sorted_vals[half];
    if (held_count % 2 == 0) begin
      lo_mid = sorted_vals[half-1];
      return hi_mid + lo_mid;
    end
    return hi_mid + hi_mid;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    median_word_t got;
    median_word_t want;
    if (!rst_ni) begin
      held_count     = 0;
      set_overflowed = 1'b0;
      mismatches     = 0;
      medians_due_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (held_count < CAPACITY) begin
          insert_value(rsm_value_t'(value_i[VALUE_BITS-1:0]));
        end else begin
          set_overflowed = 1'b1;
        end
        if (last_i) begin
          want.median_twice = twice_median();
          want.item_count   = ITEM_CNT_W'(held_count);
          want.overflow     = set_overflowed;
          medians_due_q.push_back(want);
          held_count     = 0;
          set_overflowed = 1'b0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        got.median_twice = median_twice_i;
        got.item_count   = item_count_i;
        got.overflow     = overflow_i;
        if (medians_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word with none due: median_twice=%0d count=%0d ovf=%0b",
                     $time, got.median_twice, got.item_count, got.overflow);
          end
        end else begin
          want = medians_due_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: median_twice exp %0d got %0d,",
                       $time, want.median_twice, got.median_twice,
                       " count exp %0d got %0d, ovf exp %0b got %0b",
                       want.item_count, got.item_count, want.overflow, got.overflow);
            end
          end
        end
      end
      pending_o        <= medians_due_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== dv/running_set_median_core_tb.sv =====
`timescale 1ns / 1ps
module running_set_median_core_tb;
  import rsm_pkg::*;

  localparam int ITEM_TARGET   = 1750;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [31:0] value_i     = '0;
  logic        last_i      = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic signed [32:0] median_twice_o;
  logic [6:0]  item_count_o;
  logic        overflow_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count  = 0;
  int unsigned words_sent   = 0;
  int unsigned in_idle_pct  = 14;
  int unsigned out_idle_pct = 14;
  bit          hold_request = 1'b0;

  running_set_median_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_twice_o (median_twice_o),
    .item_count_o   (item_count_o),
    .overflow_o     (overflow_o)
  );

  running_set_median_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .value_i          (value_i),
    .last_i           (last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .median_twice_i   (median_twice_o),
    .item_count_i     (item_count_o),
    .overflow_i       (overflow_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    int unsigned r;
    int          s;
    r = $urandom_range(99);
    if (r < 50) return $urandom();
    if (r < 75) begin
      // narrow range: plenty of duplicates
      s = int'($urandom_range(16)) - 8;
      return s;
    end
    if (r < 88) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if ($urandom_range(1)) return 32'h7FFF_FFFF - $urandom_range(3);
    return 32'h8000_0000 + $urandom_range(3);
  endfunction

  function automatic int pick_set_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(40, 9);
    if (r < 97) return $urandom_range(64, 41);
    return $urandom_range(72, 65);
  endfunction

  task automatic push_word(input logic [31:0] v, input logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) begin
      push_word(pick_value(), i == n - 1);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-value sets at both extremes
    push_word(32'h7FFF_FFFF, 1'b1);
    push_word(32'h8000_0000, 1'b1);
    // even sets: largest sum, smallest sum, mixed signs
    push_word(32'h7FFF_FFFF, 1'b0);
    push_word(32'h7FFF_FFFF, 1'b1);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h8000_0000, 1'b1);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h7FFF_FFFF, 1'b1);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    // odd set with equal values
    push_word(32'd5, 1'b0);
    push_word(-32'sd3, 1'b0);
    push_word(32'd5, 1'b1);
    // descending input forces insertion at the bottom each time
    push_word(32'd3, 1'b0);
    push_word(32'd2, 1'b0);
    push_word(32'd1, 1'b0);
    push_word(32'd0, 1'b1);

    // just below, at, and past capacity; past it the last word itself is dropped
    send_set(CAPACITY - 1);
    send_set(CAPACITY);
    send_set(CAPACITY + 1);
    send_set(CAPACITY + 2);

    while (words_sent < 600) send_set(pick_set_size());

    // no idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (words_sent < 1000) send_set(pick_set_size());

    // long receiver hold-off while sets keep coming
    in_idle_pct  = 14;
    out_idle_pct = 14;
    hold_request = 1'b1;
    while (words_sent < 1250) send_set($urandom_range(24, 4));

    while (words_sent < ITEM_TARGET) send_set(pick_set_size());
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
